### src/sacl_pkg.sv
// Shared types, constants and helpers for the set-associative cache lookup core.
package sacl_pkg;

    // Default parameter values
    localparam int MAX_SET_BITS_DEF = 6;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int ADDR_WIDTH_DEF   = 48;

    // Field widths fixed by the interface
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int SET_BITS_W = 3;
    localparam int WAYS_CFG_W = 4;
    localparam int BLK_BITS_W = 5;
    localparam int WAYS_EFF_W = 5;
    localparam int SB_W       = 4;
    localparam int SHIFT_W    = 6;

    // LRU age: 0 is most recent, saturates at the top value
    localparam int                AGE_W   = 3;
    localparam logic [AGE_W-1:0]  AGE_TOP = 3'd7;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_STORE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MODIFY = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic clear;
        logic accept;
        logic lookup;
    } t_ctrl_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic clear_last;
    } t_dp_status;

    function automatic logic [AGE_W-1:0] age_up(input logic [AGE_W-1:0] a);
        age_up = (a == AGE_TOP) ? a : a + 1'b1;
    endfunction

endpackage

### src/sacl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/sacl_ctrl.sv
// Sequencer: clearing pass after reset, then accept / lookup per item.
module sacl_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  sacl_pkg::t_dp_status  i_status,
    output sacl_pkg::t_ctrl_cmd   o_cmd,
    output logic                  o_busy
);
    import sacl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### src/sacl_dpath.sv
// Datapath: config registers, set/tag split, set RAM, way compare and LRU update.
module sacl_dpath #(
    parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF,
    parameter int ADDR_WIDTH   = sacl_pkg::ADDR_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sacl_pkg::t_ctrl_cmd               i_cmd,
    output sacl_pkg::t_dp_status              o_status,
    input  logic                              i_cfg_valid,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [sacl_pkg::REQ_W-1:0]        i_req_type,
    input  logic [ADDR_WIDTH-1:0]             i_address,
    output logic                              o_done,
    output logic [1:0]                        o_hit_count,
    output logic                              o_missed,
    output logic                              o_evicted
);
    import sacl_pkg::*;

    localparam int NUM_SETS = 2 ** MAX_SET_BITS;
    localparam int SET_AW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_IW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_W    = 1 + AGE_W + ADDR_WIDTH;
    localparam int ROW_W    = MAX_WAYS * WAY_W;

    // Configuration
    logic [SET_BITS_W-1:0] r_set_bits;
    logic [WAYS_CFG_W-1:0] r_ways_cfg;
    logic [BLK_BITS_W-1:0] r_block_bits;

    // Item registers
    logic [REQ_W-1:0]      r_req_type;
    logic [SET_AW-1:0]     r_set;
    logic [ADDR_WIDTH-1:0] r_tag;
    logic [SET_AW-1:0]     r_clr_addr;

    // Result registers
    logic       r_done;
    logic [1:0] r_hit_count;
    logic       r_missed;
    logic       r_evicted;

    // Address split
    logic [SB_W-1:0]       sb;
    logic [SHIFT_W-1:0]    tag_shift;
    logic [ADDR_WIDTH-1:0] addr_blk;
    logic [SET_AW-1:0]     set_idx;
    logic [WAYS_EFF_W-1:0] ways_eff;

    // RAM
    logic              ram_we;
    logic [SET_AW-1:0] ram_waddr;
    logic [SET_AW-1:0] ram_raddr;
    logic [ROW_W-1:0]  ram_wdata;
    logic [ROW_W-1:0]  ram_rdata;

    // Way decode
    logic                  v_valid [MAX_WAYS];
    logic [AGE_W-1:0]      v_age   [MAX_WAYS];
    logic [ADDR_WIDTH-1:0] v_tag   [MAX_WAYS];
    logic [MAX_WAYS-1:0]   in_use;
    logic [MAX_WAYS-1:0]   match;

    logic              hit;
    logic [WAY_IW-1:0] hit_way;
    logic              free_any;
    logic [WAY_IW-1:0] free_way;
    logic [WAY_IW-1:0] victim;
    logic [WAY_IW-1:0] slot;
    logic [AGE_W-1:0]  old_age;
    logic [ROW_W-1:0]  row_new;

    always_comb begin
        sb        = (int'(r_set_bits) > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS) : SB_W'(r_set_bits);
        tag_shift = SHIFT_W'(r_block_bits) + SHIFT_W'(sb);
        addr_blk  = i_address >> r_block_bits;
        set_idx   = addr_blk[SET_AW-1:0] & ~({SET_AW{1'b1}} << sb);
        if (r_ways_cfg == '0) begin
            ways_eff = WAYS_EFF_W'(1);
        end else if (int'(r_ways_cfg) > MAX_WAYS) begin
            ways_eff = WAYS_EFF_W'(MAX_WAYS);
        end else begin
            ways_eff = WAYS_EFF_W'(r_ways_cfg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= '0;
            r_ways_cfg   <= WAYS_CFG_W'(1);
            r_block_bits <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SET_BITS:   r_set_bits   <= i_cfg_data[SET_BITS_W-1:0];
                CFG_WAYS:       r_ways_cfg   <= i_cfg_data[WAYS_CFG_W-1:0];
                CFG_BLOCK_BITS: r_block_bits <= i_cfg_data[BLK_BITS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign o_status.clear_last = (r_clr_addr == SET_AW'(NUM_SETS - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req_type <= i_req_type;
            r_set      <= set_idx;
            r_tag      <= i_address >> tag_shift;
        end
    end

    // Set RAM: one row per set, each way {valid, age, tag}
    assign ram_raddr = set_idx;
    assign ram_we    = i_cmd.clear | i_cmd.lookup;
    assign ram_waddr = i_cmd.clear ? r_clr_addr : r_set;
    assign ram_wdata = i_cmd.clear ? '0 : row_new;

    sacl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            v_tag[w]   = ram_rdata[w*WAY_W +: ADDR_WIDTH];
            v_age[w]   = ram_rdata[w*WAY_W + ADDR_WIDTH +: AGE_W];
            v_valid[w] = ram_rdata[w*WAY_W + ADDR_WIDTH + AGE_W];
            in_use[w]  = (w < int'(ways_eff));
            match[w]   = in_use[w] & v_valid[w] & (v_tag[w] == r_tag);
        end
    end

    // Way selection: lowest hit, lowest free, oldest valid (highest way on ties)
    always_comb begin
        logic             have_v;
        logic [AGE_W-1:0] best;
        hit      = |match;
        hit_way  = '0;
        free_any = 1'b0;
        free_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = WAY_IW'(w);
            end
            if (in_use[w] && !v_valid[w]) begin
                free_any = 1'b1;
                free_way = WAY_IW'(w);
            end
        end
        have_v = 1'b0;
        best   = '0;
        victim = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (in_use[w] && v_valid[w] && (!have_v || v_age[w] >= best)) begin
                have_v = 1'b1;
                best   = v_age[w];
                victim = WAY_IW'(w);
            end
        end
        old_age = v_age[hit_way];
        slot    = free_any ? free_way : victim;
    end

    // Updated row
    always_comb begin
        logic                  nv;
        logic [AGE_W-1:0]      na;
        logic [ADDR_WIDTH-1:0] nt;
        row_new = ram_rdata;
        for (int w = 0; w < MAX_WAYS; w++) begin
            nv = v_valid[w];
            na = v_age[w];
            nt = v_tag[w];
            if (in_use[w]) begin
                if (hit) begin
                    if (WAY_IW'(w) == hit_way) begin
                        na = '0;
                    end else if (v_valid[w] && v_age[w] < old_age) begin
                        na = age_up(v_age[w]);
                    end
                end else begin
                    if (WAY_IW'(w) == slot) begin
                        nv = 1'b1;
                        na = '0;
                        nt = r_tag;
                    end else if (v_valid[w]) begin
                        na = age_up(v_age[w]);
                    end
                end
            end
            row_new[w*WAY_W +: WAY_W] = {nv, na, nt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.lookup;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_hit_count <= {1'b0, (r_req_type == REQ_MODIFY)} + {1'b0, hit};
            r_missed    <= ~hit;
            r_evicted   <= ~hit & ~free_any;
        end
    end

    assign o_done      = r_done;
    assign o_hit_count = r_hit_count;
    assign o_missed    = r_missed;
    assign o_evicted   = r_evicted;

endmodule

### src/set_assoc_cache_lru_lookup_core.sv
// Top level of the set-associative cache tag and LRU lookup core.
//
// Tag/LRU engine for a set-associative cache. Pulse start with a request
// kind (load, store, modify) and a byte address while busy is low; the item
// is taken at that edge. The address drops block_bits offset bits, the next
// set_bits bits pick the set and everything above is the tag. Each item
// goes through an accept step, which reads the whole set row from the set
// RAM (registered read), then a lookup step, which compares every way in
// parallel and writes back the ages and any filled line. The result shows on
// o_hit_count / o_missed / o_evicted for exactly one cycle with o_done high,
// in the cycle after the lookup; busy is already low then, so a new item may
// be started in that same cycle. The receiver cannot stall results: sample
// them whenever o_done is high. After reset the block sweeps the set RAM once
// to clear valid bits and ages, one set per cycle over all 2**MAX_SET_BITS
// sets (64 at default), with busy high. Configuration writes are always taken
// (o_cfg_ready is tied high) and should be made only while idle; an index
// past the register list is ignored.
module set_assoc_cache_lru_lookup_core #(
    parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF,
    parameter int ADDR_WIDTH   = sacl_pkg::ADDR_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Item request
    input  logic                              start,
    output logic                              busy,
    input  logic [sacl_pkg::REQ_W-1:0]        i_req_type,
    input  logic [ADDR_WIDTH-1:0]             i_address,
    // Result
    output logic                              o_done,
    output logic [1:0]                        o_hit_count,
    output logic                              o_missed,
    output logic                              o_evicted,
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import sacl_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // Register file never back-pressures
    assign o_cfg_ready = 1'b1;

    sacl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    sacl_dpath #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDR_WIDTH   (ADDR_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_valid (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req_type  (i_req_type),
        .i_address   (i_address),
        .o_done      (o_done),
        .o_hit_count (o_hit_count),
        .o_missed    (o_missed),
        .o_evicted   (o_evicted)
    );

endmodule

### sim/tb.sv
// Self-checking testbench for the set-associative cache tag and LRU lookup core.
module tb;
    import sacl_pkg::*;

    // Request kind 3 is not defined; the core treats it as a load
    localparam logic [REQ_W-1:0]     REQ_UNUSED = 2'd3;
    // Register index past the list, ignored by the core
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int NUM_SETS  = 1 << MAX_SET_BITS_DEF;
    localparam int NUM_LINES = NUM_SETS * MAX_WAYS_DEF;

    // One lookup outcome, as the core reports it
    typedef struct packed {
        logic [1:0] hit_count;
        logic       missed;
        logic       evicted;
    } t_access_outcome;

    // Keeps its own copy of the tag store, the LRU ages and the config
    // registers, predicts each lookup when the core takes it and checks the
    // outcomes in order.
    class cache_scoreboard;
        bit                          line_ok   [NUM_LINES];
        bit [ADDR_WIDTH_DEF-1:0]     line_tag  [NUM_LINES];
        bit [AGE_W-1:0]              line_age  [NUM_LINES];
        bit [SET_BITS_W-1:0]         cfg_set_bits;
        bit [WAYS_CFG_W-1:0]         cfg_ways;
        bit [BLK_BITS_W-1:0]         cfg_block_bits;
        t_access_outcome             outcome_q [$];
        int                          errors;

        function new();
            foreach (line_ok[i]) begin
                line_ok[i]  = 1'b0;
                line_tag[i] = '0;
                line_age[i] = '0;
            end
            cfg_set_bits   = 3'd0;
            cfg_ways       = 4'd1;
            cfg_block_bits = 5'd0;
            errors         = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SET_BITS:   cfg_set_bits   = data[SET_BITS_W-1:0];
                CFG_WAYS:       cfg_ways       = data[WAYS_CFG_W-1:0];
                CFG_BLOCK_BITS: cfg_block_bits = data[BLK_BITS_W-1:0];
                default: ;
            endcase
        endfunction

        // Works out the outcome of one lookup and updates the line state
        function void note_access(input logic [REQ_W-1:0] kind,
                                  input logic [ADDR_WIDTH_DEF-1:0] addr);
            int sb, nways, sh, set_idx, base, hit_way, free_way, victim, slot, e;
            bit have_victim;
            bit [AGE_W-1:0] best, old_age;
            bit [ADDR_WIDTH_DEF-1:0] tag;
            t_access_outcome r;
            sb = (cfg_set_bits > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : int'(cfg_set_bits);
            nways = (cfg_ways == 0) ? 1 :
                    (cfg_ways > MAX_WAYS_DEF) ? MAX_WAYS_DEF : int'(cfg_ways);
            sh = int'(cfg_block_bits) + sb;
            set_idx = int'((addr >> cfg_block_bits) & ((48'd1 << sb) - 48'd1));
            tag = addr >> sh;
            base = set_idx * MAX_WAYS_DEF;
            r.hit_count = (kind == REQ_MODIFY) ? 2'd1 : 2'd0;
            r.missed = 1'b0;
            r.evicted = 1'b0;
            hit_way = -1;
            free_way = -1;
            victim = 0;
            best = '0;
            have_victim = 1'b0;
            // first matching way wins; the oldest valid way is the victim,
            // the highest numbered one on a tie
            for (int w = 0; w < nways && hit_way < 0; w++) begin
                e = base + w;
                if (line_ok[e]) begin
                    if (line_tag[e] == tag) begin
                        hit_way = w;
                    end else if (!have_victim || line_age[e] >= best) begin
                        best = line_age[e];
                        victim = w;
                        have_victim = 1'b1;
                    end
                end else if (free_way < 0) begin
                    free_way = w;
                end
            end
            if (hit_way >= 0) begin
                old_age = line_age[base + hit_way];
                r.hit_count = r.hit_count + 2'd1;
                for (int w = 0; w < nways; w++) begin
                    e = base + w;
                    if (line_ok[e] && line_age[e] < old_age && line_age[e] != AGE_TOP)
                        line_age[e] = line_age[e] + 3'd1;
                end
                line_age[base + hit_way] = '0;
            end else begin
                r.missed = 1'b1;
                if (free_way >= 0) begin
                    slot = free_way;
                end else begin
                    slot = victim;
                    r.evicted = 1'b1;
                end
                for (int w = 0; w < nways; w++) begin
                    e = base + w;
                    if (line_ok[e] && line_age[e] != AGE_TOP)
                        line_age[e] = line_age[e] + 3'd1;
                end
                line_ok[base + slot]  = 1'b1;
                line_tag[base + slot] = tag;
                line_age[base + slot] = '0;
            end
            outcome_q.push_back(r);
        endfunction

        function void check_result(input logic [1:0] hit_count,
                                   input logic missed, input logic evicted);
            t_access_outcome want;
            if (outcome_q.size() == 0) begin
                $error("result with no lookup pending: hit_count %0d missed %0d evicted %0d",
                       hit_count, missed, evicted);
                errors++;
                return;
            end
            want = outcome_q.pop_front();
            if (hit_count !== want.hit_count) begin
                $error("hit_count: expected %0d, got %0d", want.hit_count, hit_count);
                errors++;
            end
            if (missed !== want.missed) begin
                $error("missed: expected %0d, got %0d", want.missed, missed);
                errors++;
            end
            if (evicted !== want.evicted) begin
                $error("evicted: expected %0d, got %0d", want.evicted, evicted);
                errors++;
            end
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [REQ_W-1:0]        i_req_type;
    logic [ADDR_WIDTH_DEF-1:0] i_address;
    logic                    o_done;
    logic [1:0]              o_hit_count;
    logic                    o_missed;
    logic                    o_evicted;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    cache_scoreboard sb;

    set_assoc_cache_lru_lookup_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req_type  (i_req_type),
        .i_address   (i_address),
        .o_done      (o_done),
        .o_hit_count (o_hit_count),
        .o_missed    (o_missed),
        .o_evicted   (o_evicted),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Results cannot be held off: every o_done cycle is an accepted result.
    // Sampled right at the rising edge, before the core's updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_result(o_hit_count, o_missed, o_evicted);
    end

    // Hard stop in case the core hangs on a handshake
    initial begin
        #2000000;
        $display("FAIL set_assoc_cache_lru_lookup_core");
        $finish;
    end

    // Drives one lookup from a falling edge and holds it until the core takes
    // it. Returns on a falling edge, after an optional gap with start low (taken
    // in idle_pct percent of calls); without a gap start is still high, so back-to-back items keep start up.
    task automatic send_access(input logic [REQ_W-1:0] kind,
                               input logic [ADDR_WIDTH_DEF-1:0] addr,
                               input int idle_pct);
        start      = 1'b1;
        i_req_type = kind;
        i_address  = addr;
        do @(posedge i_clk); while (busy);
        sb.note_access(kind, addr);
        @(negedge i_clk);
        if ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge i_clk);
        end
    endtask

    // Stops issuing and lets every outstanding result come back.
    // Every lookup gives a result, so it waits until none is pending, then idles.
    task automatic drain();
        int n;
        start = 1'b0;
        n = 0;
        while (sb.pending() != 0 && n < 1000) begin
            @(negedge i_clk);
            n++;
        end
        repeat (3) @(negedge i_clk);
    endtask

    // Register write; called from a falling edge with the core idle
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] set_bits,
                              input logic [CFG_DATA_W-1:0] ways,
                              input logic [CFG_DATA_W-1:0] block_bits);
        drain();
        write_cfg(CFG_SET_BITS, set_bits);
        write_cfg(CFG_WAYS, ways);
        write_cfg(CFG_BLOCK_BITS, block_bits);
    endtask

    // Random lookups under the current config. Most addresses are built from
    // a small pool of tags and sets so lines are hit, filled and evicted;
    // the rest are fully random 48-bit addresses.
    task automatic run_random(input int count, input int idle_pct);
        int sbe, sh;
        logic [ADDR_WIDTH_DEF-1:0] addr, tag_part, set_part, off;
        logic [REQ_W-1:0] kind;
        sbe = (sb.cfg_set_bits > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF
                                                   : int'(sb.cfg_set_bits);
        sh = int'(sb.cfg_block_bits) + sbe;
        for (int k = 0; k < count; k++) begin
            kind = REQ_W'($urandom_range(3));
            if ($urandom_range(99) < 15) begin
                addr = {16'($urandom), $urandom};
            end else begin
                off = {16'($urandom), $urandom};
                off = off & ((48'd1 << sb.cfg_block_bits) - 48'd1);
                set_part = 48'($urandom_range(3)) & ((48'd1 << sbe) - 48'd1);
                if ($urandom_range(9) == 0)
                    tag_part = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(3));
                else
                    tag_part = 48'($urandom_range(11));
                addr = (tag_part << sh) | (set_part << sb.cfg_block_bits) | off;
            end
            send_access(kind, addr, idle_pct);
        end
    endtask

    // Sender gap rate per random config phase: light, heavy, none
    function automatic int gap_pct(input int phase);
        return (phase < 3) ? 10 : (phase < 6) ? 47 : 0;
    endfunction

    initial begin
        logic [CFG_DATA_W-1:0] ph_sets  [9];
        logic [CFG_DATA_W-1:0] ph_ways  [9];
        logic [CFG_DATA_W-1:0] ph_block [9];
        sb = new();
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req_type  = REQ_LOAD;
        i_address   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_SET_BITS;
        i_cfg_data  = '0;
        // Config phases: clamped set bits, zero and oversized way counts,
        // widest block offset, and data with the unused upper bits set
        ph_sets  = '{5'd2, 5'd0, 5'd6,  5'd7,  5'd3, 5'd14, 5'd1,  5'd4,  5'd5};
        ph_ways  = '{5'd4, 5'd8, 5'd8,  5'd2,  5'd0, 5'd24, 5'd15, 5'd3,  5'd8};
        ph_block = '{5'd6, 5'd0, 5'd16, 5'd31, 5'd4, 5'd3,  5'd1,  5'd10, 5'd2};

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset config: one set, one way, no offset. The first lookup also
        // waits out the post-reset clearing sweep.
        send_access(REQ_LOAD, 48'h0, 10);
        send_access(REQ_LOAD, 48'h0, 10);
        send_access(REQ_STORE, 48'hFFFF_FFFF_FFFF, 10);
        send_access(REQ_MODIFY, 48'hFFFF_FFFF_FFFF, 10);
        send_access(REQ_UNUSED, 48'hFFFF_FFFF_FFFF, 10);
        send_access(REQ_MODIFY, 48'h123, 10);

        // Write to a nonexistent register, then the widest split: set bits
        // clamp to 6, ways clamp to 8, 31 offset bits. Ten tags into one set
        // fill every way, saturate ages and force evictions.
        drain();
        write_cfg(CFG_UNUSED, 5'd31);
        set_config(5'd7, 5'd15, 5'd31);
        for (int t = 0; t < 10; t++)
            send_access(REQ_LOAD, (48'(t) << 37) | (48'd5 << 31) | 48'h7FFF_FFFF, 10);
        send_access(REQ_STORE, (48'd9 << 37) | (48'd5 << 31), 10);
        send_access(REQ_LOAD, 48'd5 << 31, 10);

        // Zero ways acts as one; the other ways keep their lines
        set_config(5'd1, 5'd0, 5'd5);
        send_access(REQ_LOAD, 48'h20, 10);
        send_access(REQ_MODIFY, 48'h20, 10);
        send_access(REQ_LOAD, 48'h420, 10);

        // Back to eight ways: stale ages next to fresh ones give victim ties
        set_config(5'd7, 5'd8, 5'd31);
        send_access(REQ_LOAD, (48'd11 << 37) | (48'd5 << 31), 10);
        send_access(REQ_STORE, (48'd12 << 37) | (48'd5 << 31), 10);

        for (int p = 0; p < 9; p++) begin
            set_config(ph_sets[p], ph_ways[p], ph_block[p]);
            run_random(61, gap_pct(p));
        end

        drain();
        repeat (5) @(negedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d results never arrived", sb.pending());
        end
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS set_assoc_cache_lru_lookup_core");
        end else begin
            $display("FAIL set_assoc_cache_lru_lookup_core");
        end
        $finish;
    end

endmodule
